// ===== rtl/cptq_pkg.sv =====
// package: shared constants, request and status codes of the task queue
package cptq_pkg;

  localparam int unsigned DepthDef      = 16;
  localparam int unsigned CountWidthDef = 16;

  localparam int unsigned TagW   = 16;
  localparam int unsigned FieldW = 16;
  localparam int unsigned RankW  = 32;
  localparam int unsigned CapW   = 5;
  localparam int unsigned OccW   = 5;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned ApbAw  = 3;
  localparam int unsigned ApbDw  = 32;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_CLOSED    = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_e;

endpackage

// ===== rtl/cost_priority_task_queue.sv =====
// top level: bounded priority task queue with sequential pop scan
// push, close, unused code and pop on empty: result strobe in the cycle after start
// pop of a non-empty queue: one memory read and one pass of the shared comparator
//   per held entry, busy high meanwhile
// one result per transaction, shown for one cycle; the receiver cannot stall
// async reset clears count, rank counter, closed mark and capacity; memory is not cleared
module cost_priority_task_queue #(
  parameter int unsigned DEPTH       = cptq_pkg::DepthDef,
  parameter int unsigned COUNT_WIDTH = cptq_pkg::CountWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [cptq_pkg::ReqW-1:0]   req_type_i,
  input  logic [cptq_pkg::TagW-1:0]   task_tag_i,
  input  logic [cptq_pkg::FieldW-1:0] merged_count_i,
  input  logic [cptq_pkg::FieldW-1:0] current_count_i,
  input  logic [cptq_pkg::FieldW-1:0] context_count_i,
  output logic                        result_valid_o,
  output logic [cptq_pkg::StatW-1:0]  status_o,
  output logic [cptq_pkg::TagW-1:0]   popped_tag_o,
  output logic [cptq_pkg::FieldW-1:0] popped_merged_o,
  output logic [cptq_pkg::FieldW-1:0] popped_current_o,
  output logic [cptq_pkg::FieldW-1:0] popped_context_o,
  output logic [cptq_pkg::OccW-1:0]   occupancy_o,
  output logic                        queue_closed_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cptq_pkg::ApbAw-1:0]  paddr,
  input  logic [cptq_pkg::ApbDw-1:0]  pwdata,
  output logic [cptq_pkg::ApbDw-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned TW   = cptq_pkg::TagW;
  localparam int unsigned RW   = cptq_pkg::RankW;
  localparam int unsigned EW   = TW + 3 * CW + RW;
  localparam int unsigned MLo  = TW;
  localparam int unsigned CLo  = TW + CW;
  localparam int unsigned XLo  = TW + 2 * CW;
  localparam int unsigned RLo  = TW + 3 * CW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  logic [CNTW-1:0]             count_q, count_d;
  logic [RW-1:0]               next_rank_q, next_rank_d;
  logic                        closed_q, closed_d;
  logic [cptq_pkg::CapW-1:0]   cap_q;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               best_idx_q, best_idx_d;
  logic [EW-1:0]               best_q, best_d;
  logic                        valid_q, valid_d;
  logic [cptq_pkg::StatW-1:0]  status_q, status_d;
  logic [EW-1:0]               pop_q, pop_d;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [EW-1:0]               mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [EW-1:0]               mem_rdata;

  logic [CNTW-1:0]             limit;
  logic                        a_wins;
  logic                        take;
  logic                        scan_last;
  logic [EW-1:0]               best_fin;
  logic [AW-1:0]               best_idx_fin;
  logic                        cfg_wr;

  // capacity register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : cptq_pkg::ApbDw'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_wr && !paddr[2]) begin
      cap_q <= pwdata[cptq_pkg::CapW-1:0];
    end
  end

  always_comb begin
    if ((cap_q == '0) || (32'(cap_q) > DEPTH)) begin
      limit = CNTW'(DEPTH);
    end else begin
      limit = CNTW'(cap_q);
    end
  end

  cptq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cptq_cmp #(
    .COUNT_WIDTH (CW)
  ) u_cmp (
    .a_merged_i  (mem_rdata[MLo +: CW]),
    .a_current_i (mem_rdata[CLo +: CW]),
    .a_context_i (mem_rdata[XLo +: CW]),
    .a_rank_i    (mem_rdata[RLo +: RW]),
    .b_merged_i  (best_q[MLo +: CW]),
    .b_current_i (best_q[CLo +: CW]),
    .b_context_i (best_q[XLo +: CW]),
    .b_rank_i    (best_q[RLo +: RW]),
    .next_rank_i (next_rank_q),
    .a_wins_o    (a_wins)
  );

  assign take         = (idx_q == '0) || a_wins;
  assign best_fin     = take ? mem_rdata : best_q;
  assign best_idx_fin = take ? idx_q : best_idx_q;
  assign scan_last    = (CNTW'(idx_q) + CNTW'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    next_rank_d = next_rank_q;
    closed_d    = closed_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    valid_d     = 1'b0;
    status_d    = status_q;
    pop_d       = pop_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          pop_d    = '0;
          status_d = cptq_pkg::ST_DONE;
          case (req_type_i)
            cptq_pkg::REQ_PUSH: begin
              valid_d = 1'b1;
              if (closed_q) begin
                status_d = cptq_pkg::ST_CLOSED;
              end else if (count_q >= limit) begin
                status_d = cptq_pkg::ST_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(count_q);
                mem_wdata   = {next_rank_q, CW'(context_count_i), CW'(current_count_i),
                               CW'(merged_count_i), task_tag_i};
                next_rank_d = next_rank_q + RW'(1);
                count_d     = count_q + CNTW'(1);
              end
            end
            cptq_pkg::REQ_POP: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = cptq_pkg::ST_POP_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = '0;
                state_d   = S_SCAN;
              end
            end
            cptq_pkg::REQ_CLOSE: begin
              valid_d  = 1'b1;
              closed_d = 1'b1;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          // move the last entry into the freed slot
          mem_we    = 1'b1;
          mem_waddr = best_idx_fin;
          mem_wdata = mem_rdata;
          count_d   = count_q - CNTW'(1);
          valid_d   = 1'b1;
          status_d  = cptq_pkg::ST_DONE;
          pop_d     = best_fin;
          state_d   = S_IDLE;
        end else begin
          best_d     = best_fin;
          best_idx_d = best_idx_fin;
          mem_re     = 1'b1;
          mem_raddr  = idx_q + AW'(1);
          idx_d      = idx_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_rank_q <= '0;
      closed_q    <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_rank_q <= next_rank_d;
      closed_q    <= closed_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    status_q   <= status_d;
    pop_q      <= pop_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign popped_tag_o     = pop_q[TW-1:0];
  assign popped_merged_o  = cptq_pkg::FieldW'(pop_q[MLo +: CW]);
  assign popped_current_o = cptq_pkg::FieldW'(pop_q[CLo +: CW]);
  assign popped_context_o = cptq_pkg::FieldW'(pop_q[XLo +: CW]);
  assign occupancy_o      = cptq_pkg::OccW'(count_q);
  assign queue_closed_o   = closed_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count above depth");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> count_q != '0)
    else $error("scan with empty queue");

  a_pop_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == cptq_pkg::REQ_POP && count_q != '0)
    |=> state_q == S_SCAN && !valid_q)
    else $error("pop did not start scan");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == cptq_pkg::ST_POP_EMPTY) |-> count_q == '0)
    else $error("empty status with held entries");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("closed mark dropped");

endmodule

// ===== rtl/cptq_mem.sv =====
// entry memory: one write port, one registered read port
module cptq_mem #(
  parameter int unsigned DEPTH = cptq_pkg::DepthDef,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cptq_cmp.sv =====
// shared compare unit: lexicographic cost keys, then greater age wins
module cptq_cmp #(
  parameter int unsigned COUNT_WIDTH = cptq_pkg::CountWidthDef
) (
  input  logic [COUNT_WIDTH-1:0]     a_merged_i,
  input  logic [COUNT_WIDTH-1:0]     a_current_i,
  input  logic [COUNT_WIDTH-1:0]     a_context_i,
  input  logic [cptq_pkg::RankW-1:0] a_rank_i,
  input  logic [COUNT_WIDTH-1:0]     b_merged_i,
  input  logic [COUNT_WIDTH-1:0]     b_current_i,
  input  logic [COUNT_WIDTH-1:0]     b_context_i,
  input  logic [cptq_pkg::RankW-1:0] b_rank_i,
  input  logic [cptq_pkg::RankW-1:0] next_rank_i,
  output logic                       a_wins_o
);

  logic [3*COUNT_WIDTH-1:0]   key_a;
  logic [3*COUNT_WIDTH-1:0]   key_b;
  logic [cptq_pkg::RankW-1:0] age_a;
  logic [cptq_pkg::RankW-1:0] age_b;

  assign key_a = {a_merged_i, a_current_i, a_context_i};
  assign key_b = {b_merged_i, b_current_i, b_context_i};
  assign age_a = next_rank_i - a_rank_i;
  assign age_b = next_rank_i - b_rank_i;

  assign a_wins_o = (key_a > key_b) || ((key_a == key_b) && (age_a > age_b));

endmodule

// ===== test/cost_priority_task_queue_tb.sv =====
// testbench: directed and random request transactions against a priority queue shadow
`timescale 1ns / 100ps

module cost_priority_task_queue_tb;
  import cptq_pkg::*;

  localparam int unsigned DEPTH       = DepthDef;
  localparam int unsigned N_PHASES    = 9;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_ROWS    = 32;
  localparam int unsigned PEND_AW     = 6;
  localparam logic [ApbAw-1:0] CAP_ADDR = '0;

  typedef struct packed {
    req_e              req;
    logic [TagW-1:0]   tag;
    logic [FieldW-1:0] merged;
    logic [FieldW-1:0] current;
    logic [FieldW-1:0] ctx;
  } task_req_t;

  typedef struct packed {
    status_e           status;
    logic [TagW-1:0]   tag;
    logic [FieldW-1:0] merged;
    logic [FieldW-1:0] current;
    logic [FieldW-1:0] ctx;
    logic [OccW-1:0]   occ;
    logic              closed;
  } queue_resp_t;

  typedef struct packed {
    task_req_t   rq;
    logic        typed;
    queue_resp_t want;
  } stim_row_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic [ReqW-1:0]   req_type_i      = '0;
  logic [TagW-1:0]   task_tag_i      = '0;
  logic [FieldW-1:0] merged_count_i  = '0;
  logic [FieldW-1:0] current_count_i = '0;
  logic [FieldW-1:0] context_count_i = '0;
  logic              result_valid_o;
  logic [StatW-1:0]  status_o;
  logic [TagW-1:0]   popped_tag_o;
  logic [FieldW-1:0] popped_merged_o;
  logic [FieldW-1:0] popped_current_o;
  logic [FieldW-1:0] popped_context_o;
  logic [OccW-1:0]   occupancy_o;
  logic              queue_closed_o;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [ApbAw-1:0]  paddr           = '0;
  logic [ApbDw-1:0]  pwdata          = '0;
  logic [ApbDw-1:0]  prdata;
  logic              pready;

  // shadow of the queue contents
  logic [TagW-1:0]   held_tag     [DEPTH];
  logic [FieldW-1:0] held_merged  [DEPTH];
  logic [FieldW-1:0] held_current [DEPTH];
  logic [FieldW-1:0] held_ctx     [DEPTH];
  logic [RankW-1:0]  held_rank    [DEPTH];
  int unsigned       held_count = 0;
  logic [RankW-1:0]  rank_ctr   = '0;
  logic              is_closed  = 1'b0;
  logic [CapW-1:0]   cap_reg    = '0;

  // expected replies in order, as a ring
  queue_resp_t       pending_replies [2**PEND_AW];
  logic [PEND_AW:0]  pend_wr = '0;
  logic [PEND_AW:0]  pend_rd = '0;

  stim_row_t       stim_rows [MAX_ROWS];
  int unsigned     n_rows    = 0;
  int unsigned     n_opening = 0;
  logic [CapW-1:0] phase_caps [N_PHASES];

  int unsigned err_cnt   = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_served  = 0;
  int unsigned n_full    = 0;
  int unsigned cycle_cnt = 0;
  logic        idle_on   = 1'b1;

  cost_priority_task_queue u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .task_tag_i      (task_tag_i),
    .merged_count_i  (merged_count_i),
    .current_count_i (current_count_i),
    .context_count_i (context_count_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .popped_tag_o    (popped_tag_o),
    .popped_merged_o (popped_merged_o),
    .popped_current_o(popped_current_o),
    .popped_context_o(popped_context_o),
    .occupancy_o     (occupancy_o),
    .queue_closed_o  (queue_closed_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pend_count();
    logic [PEND_AW:0] diff;
    diff = pend_wr - pend_rd;
    return int'(diff);
  endfunction

  function automatic void add_row(input stim_row_t row);
    stim_rows[n_rows] = row;
    n_rows++;
  endfunction

  function automatic queue_resp_t queue_reply(input task_req_t rq);
    queue_resp_t r;
    int unsigned lim;
    int unsigned best;
    logic        ahead;
    r = '0;
    r.status = ST_DONE;
    lim = (cap_reg == 0 || cap_reg > DEPTH) ? DEPTH : cap_reg;
    case (rq.req)
      REQ_PUSH: begin
        if (is_closed) begin
          r.status = ST_CLOSED;
        end else if (held_count >= lim) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          held_tag[held_count]     = rq.tag;
          held_merged[held_count]  = rq.merged;
          held_current[held_count] = rq.current;
          held_ctx[held_count]     = rq.ctx;
          held_rank[held_count]    = rank_ctr;
          rank_ctr   = rank_ctr + 1;
          held_count = held_count + 1;
        end
      end
      REQ_POP: begin
        if (held_count == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < held_count; i++) begin
            if (held_merged[i] != held_merged[best]) begin
              ahead = held_merged[i] > held_merged[best];
            end else if (held_current[i] != held_current[best]) begin
              ahead = held_current[i] > held_current[best];
            end else if (held_ctx[i] != held_ctx[best]) begin
              ahead = held_ctx[i] > held_ctx[best];
            end else begin
              // older entry wins a full tie, age taken modulo the rank width
              ahead = (rank_ctr - held_rank[i]) > (rank_ctr - held_rank[best]);
            end
            if (ahead) best = i;
          end
          r.tag     = held_tag[best];
          r.merged  = held_merged[best];
          r.current = held_current[best];
          r.ctx     = held_ctx[best];
          held_count = held_count - 1;
          held_tag[best]     = held_tag[held_count];
          held_merged[best]  = held_merged[held_count];
          held_current[best] = held_current[held_count];
          held_ctx[best]     = held_ctx[held_count];
          held_rank[best]    = held_rank[held_count];
          n_served++;
        end
      end
      REQ_CLOSE: is_closed = 1'b1;
      default: ;
    endcase
    r.occ    = held_count[OccW-1:0];
    r.closed = is_closed;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FieldW-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return FieldW'($urandom_range(0, 3));
      default: return FieldW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  task automatic issue(input task_req_t rq, input logic typed, input queue_resp_t want);
    int          gap;
    queue_resp_t reply;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    req_type_i      <= rq.req;
    task_tag_i      <= rq.tag;
    merged_count_i  <= rq.merged;
    current_count_i <= rq.current;
    context_count_i <= rq.ctx;
    do @(posedge clk_i); while (busy);
    reply = queue_reply(rq);
    pending_replies[pend_wr[PEND_AW-1:0]] = typed ? want : reply;
    pend_wr = pend_wr + 1'b1;
    n_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pend_count() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= ApbDw'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = value;
  endtask

  task automatic walk_rows(input int unsigned first, input int unsigned last);
    for (int unsigned i = first; i < last; i++) begin
      issue(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].want);
    end
  endtask

  always @(posedge clk_i) begin : reply_check
    queue_resp_t want;
    if (rst_ni && result_valid_o) begin
      if (pend_count() == 0) begin
        $display("%0t: reply expected none actual status %0d tag %0h", $time, status_o,
                 popped_tag_o);
        err_cnt++;
      end else begin
        want = pending_replies[pend_rd[PEND_AW-1:0]];
        pend_rd = pend_rd + 1'b1;
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("popped_tag", 32'(want.tag), 32'(popped_tag_o));
        check_field("popped_merged", 32'(want.merged), 32'(popped_merged_o));
        check_field("popped_current", 32'(want.current), 32'(popped_current_o));
        check_field("popped_context", 32'(want.ctx), 32'(popped_context_o));
        check_field("occupancy", 32'(want.occ), 32'(occupancy_o));
        check_field("queue_closed", 32'(want.closed), 32'(queue_closed_o));
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt,
               pend_count());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    task_req_t rq;
    logic      fill;
    int        mode_left;
    int        r;

    // after reset, capacity zero means full depth
    add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_POP_EMPTY, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0}});
    add_row('{'{REQ_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0}});
    add_row('{'{REQ_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd1, 1'b0}});
    add_row('{'{REQ_PUSH, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b0}});
    add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0}});
    add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0}});
    add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_POP_EMPTY, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0}});
    // key order and first-in tiebreak
    add_row('{'{REQ_PUSH, 16'h0001, 16'd5, 16'd5, 16'd5}, 1'b0, '0});
    add_row('{'{REQ_PUSH, 16'h0002, 16'd5, 16'd5, 16'd5}, 1'b0, '0});
    add_row('{'{REQ_PUSH, 16'h0003, 16'd5, 16'd6, 16'd0}, 1'b0, '0});
    add_row('{'{REQ_PUSH, 16'h0004, 16'd5, 16'd5, 16'd6}, 1'b0, '0});
    add_row('{'{REQ_PUSH, 16'h0005, 16'd4, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
    add_row('{'{REQ_NONE, 16'h1234, 16'h0, 16'h0, 16'h0}, 1'b0, '0});
    repeat (5) add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0});
    n_opening = n_rows;

    // closing sequence, run on an empty queue with capacity two
    add_row('{'{REQ_PUSH, 16'h0A0A, 16'd1, 16'd2, 16'd3}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd1, 1'b0}});
    add_row('{'{REQ_PUSH, 16'h0B0B, 16'd1, 16'd2, 16'd3}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b0}});
    add_row('{'{REQ_PUSH, 16'h0C0C, 16'd9, 16'd9, 16'd9}, 1'b1,
              '{ST_FULL, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b0}});
    add_row('{'{REQ_CLOSE, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b1}});
    add_row('{'{REQ_PUSH, 16'h0D0D, 16'd9, 16'd9, 16'd9}, 1'b1,
              '{ST_CLOSED, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b1}});
    add_row('{'{REQ_CLOSE, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd2, 1'b1}});
    add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'h0A0A, 16'd1, 16'd2, 16'd3, 5'd1, 1'b1}});
    add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'h0B0B, 16'd1, 16'd2, 16'd3, 5'd0, 1'b1}});
    add_row('{'{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_POP_EMPTY, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b1}});
    add_row('{'{REQ_NONE, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
              '{ST_DONE, 16'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b1}});

    phase_caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd0, 5'd8};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    walk_rows(0, n_opening);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_capacity(phase_caps[ph]);
      idle_on   = (ph % 3 != 1);
      fill      = 1'b1;
      mode_left = $urandom_range(8, 30);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) settle();
        if (mode_left == 0) begin
          fill      = ~fill;
          mode_left = $urandom_range(8, 30);
        end
        mode_left--;
        r = $urandom_range(0, 99);
        if (r < (fill ? 72 : 25)) rq.req = REQ_PUSH;
        else if (r < 96) rq.req = REQ_POP;
        else rq.req = REQ_NONE;
        rq.tag     = TagW'($urandom_range(0, 65535));
        rq.merged  = pick_key();
        rq.current = pick_key();
        rq.ctx     = pick_key();
        issue(rq, 1'b0, '0);
      end
    end

    idle_on = 1'b1;
    rq      = '{REQ_POP, 16'h0, 16'h0, 16'h0, 16'h0};
    while (held_count != 0) issue(rq, 1'b0, '0);
    settle();
    write_capacity(5'd2);
    walk_rows(n_opening, n_rows);

    settle();
    repeat (24) @(posedge clk_i);
    $display("sent %0d request transactions over %0d capacity settings, %0d replies compared",
             n_sent, N_PHASES + 2, n_checked);
    $display("%0d tasks served by pop, %0d pushes refused for lack of room", n_served, n_full);
    if (err_cnt == 0 && pend_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (pend_count() != 0) begin
        $display("%0t: replies expected 0 outstanding actual %0d", $time,
                 pend_count());
      end
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
